// ----- design/rbe_pkg.sv -----
// Shared types and constants for the ray/box exit point block.
// No dependencies; the top level, divider cell, slab select and move modules import this package.
package rbe_pkg;

  localparam int RW    = 63;  // remainder width inside the divider chain
  localparam int QB    = 31;  // quotient bits produced by the chain
  localparam int NLANE = 4;   // min_x, max_x, min_y, max_y
  localparam logic [31:0] TSAT = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB-1:0] quo;
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic [31:0]        dmag_x;
    logic [31:0]        dmag_y;
    logic               par_x;
    logic               par_y;
  } side_t;

  typedef struct packed {
    side_t                  side;
    lane_t [NLANE-1:0]      lane;
  } div_t;

  typedef struct packed {
    logic signed [31:0] t;
    logic               used_exit;
    logic               no_dir;
    logic               sat;
    side_t              side;
  } sel_t;

endpackage

// ----- design/rbe_in_if.sv -----
// Ray input channel: valid/ready handshake with ray and box payload.
// Standalone interface, no package dependency.
interface rbe_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic [15:0]        box_min_x;
  logic [15:0]        box_min_y;
  logic [15:0]        box_max_x;
  logic [15:0]        box_max_y;

  modport source (output valid, dir_x, dir_y, origin_x, origin_y,
                  box_min_x, box_min_y, box_max_x, box_max_y, input ready);
  modport sink   (input valid, dir_x, dir_y, origin_x, origin_y,
                  box_min_x, box_min_y, box_max_x, box_max_y, output ready);
endinterface

// ----- design/rbe_out_if.sv -----
// Hit point output channel: valid/ready handshake with point and flags.
// Standalone interface, no package dependency.
interface rbe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic               used_exit;
  logic               no_direction;
  logic               saturated;

  modport source (output valid, hit_x, hit_y, used_exit, no_direction, saturated,
                  input ready);
  modport sink   (input valid, hit_x, hit_y, used_exit, no_direction, saturated,
                  output ready);
endinterface

// ----- design/ray_box_exit_point_2d_top.sv -----
// Top level of the 2D ray/box exit point block (slab method).
// Depends on rbe_pkg, rbe_in_if, rbe_out_if, rbe_div_cell, rbe_slab_sel, rbe_move.
//
// Usage:
//  - ray_i carries one ray (Q16.16 origin and direction) plus integer box
//    bounds per transfer; hit_o returns one point with used_exit,
//    no_direction and saturated flags per ray, in order.
//  - The APB port holds one register, near_zero_limit, at byte address 0.
//    Write it only while the block is idle. Reads return its value.
//  - An input transfer passes through one input register, 31 divider cells
//    (one quotient bit each, all four slab lanes in parallel), a sort/select
//    stage, a multiply stage and the output register before its result is
//    offered on hit_o.
//  - Throughput is one ray per cycle while hit_o does not stall; the
//    divider cell chain sets the depth.
//  - Each stage advances when it is empty or its successor advances, so a
//    stall on hit_o fills bubbles first and holds ray_i ready until the
//    whole chain is full.
//  - Reset clears all stage valid bits and the register to zero.
module ray_box_exit_point_2d_top #(
  parameter int FRAC_BITS  = 16,
  parameter int BOUND_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbe_in_if.sink      ray_i,
  rbe_out_if.source   hit_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rbe_pkg::*;

  localparam int NW = ((BOUND_BITS + FRAC_BITS > 32) ? BOUND_BITS + FRAC_BITS : 32) + 2;
  localparam int WW = NW + FRAC_BITS + 32;
  localparam int NS = QB + 4;  // input reg, cells, select, multiply, output

  // ---------------- configuration ----------------
  logic [15:0] limit_q;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      limit_q <= pwdata[15:0];
    end
  end

  // ---------------- stage control ----------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // advance a stage when it is empty or the next one moves
  always_comb begin
    en[NS-1] = !v_q[NS-1] || hit_o.ready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = NS - 1; k > 0; k--) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
      if (en[0]) v_q[0] <= ray_i.valid;
    end
  end

  assign ray_i.ready = en[0];

  // ---------------- input register ----------------
  logic signed [31:0] dx_q, dy_q, ox_q, oy_q;
  logic [15:0]        bnd_q [NLANE];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q     <= ray_i.dir_x;
      dy_q     <= ray_i.dir_y;
      ox_q     <= ray_i.origin_x;
      oy_q     <= ray_i.origin_y;
      bnd_q[0] <= ray_i.box_min_x;
      bnd_q[1] <= ray_i.box_max_x;
      bnd_q[2] <= ray_i.box_min_y;
      bnd_q[3] <= ray_i.box_max_y;
    end
  end

  // ---------------- prep: numerators, overflow, start remainder ----------------
  div_t prep;

  always_comb begin
    logic [BOUND_BITS-1:0] b;
    logic signed [NW-1:0]  num, org;
    logic [NW-1:0]         n;
    logic [WW-1:0]         nsh, dsh;
    logic [31:0]           d;
    logic                  dneg;
    prep.side.dir_x  = dx_q;
    prep.side.dir_y  = dy_q;
    prep.side.org_x  = ox_q;
    prep.side.org_y  = oy_q;
    prep.side.dmag_x = dx_q[31] ? 32'(-dx_q) : dx_q;
    prep.side.dmag_y = dy_q[31] ? 32'(-dy_q) : dy_q;
    prep.side.par_x  = prep.side.dmag_x <= {16'd0, limit_q};
    prep.side.par_y  = prep.side.dmag_y <= {16'd0, limit_q};
    for (int l = 0; l < NLANE; l++) begin
      b    = BOUND_BITS'(bnd_q[l]);
      org  = (l < 2) ? NW'(ox_q) : NW'(oy_q);
      d    = (l < 2) ? prep.side.dmag_x : prep.side.dmag_y;
      dneg = (l < 2) ? dx_q[31] : dy_q[31];
      num  = $signed(NW'(b) << FRAC_BITS) - org;
      n    = num[NW-1] ? NW'(-num) : NW'(num);
      nsh  = WW'(n) << FRAC_BITS;
      dsh  = WW'(d) << QB;
      prep.lane[l].neg = num[NW-1] ^ dneg;
      prep.lane[l].ovf = nsh >= dsh;
      prep.lane[l].quo = '0;
      prep.lane[l].rem = prep.lane[l].ovf ? '0 : nsh[RW-1:0];
    end
  end

  // ---------------- divider cell chain ----------------
  div_t chain [QB+1];
  assign chain[0] = prep;

  for (genvar c = 0; c < QB; c++) begin : g_cell
    rbe_div_cell #(.J(QB - 1 - c)) u_cell (
      .clk_i (clk_i),
      .en_i  (en[c+1]),
      .d_i   (chain[c]),
      .d_o   (chain[c+1])
    );
  end

  // ---------------- select and move ----------------
  sel_t sel;

  rbe_slab_sel u_sel (
    .clk_i (clk_i),
    .en_i  (en[QB+1]),
    .d_i   (chain[QB]),
    .s_o   (sel)
  );

  rbe_move #(.FRAC_BITS(FRAC_BITS)) u_move (
    .clk_i       (clk_i),
    .en_a_i      (en[QB+2]),
    .en_b_i      (en[QB+3]),
    .s_i         (sel),
    .hit_x_o     (hit_o.hit_x),
    .hit_y_o     (hit_o.hit_y),
    .used_exit_o (hit_o.used_exit),
    .no_dir_o    (hit_o.no_direction),
    .sat_o       (hit_o.saturated)
  );

  assign hit_o.valid = v_q[NS-1];
endmodule

// ----- design/rbe_div_cell.sv -----
// One restoring-division cell: resolves quotient bit J for all four slab lanes.
// Depends on rbe_pkg.
module rbe_div_cell #(
  parameter int J = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  rbe_pkg::div_t d_i,
  output rbe_pkg::div_t d_o
);
  import rbe_pkg::*;

  div_t d_d, d_q;

  always_comb begin
    logic [RW-1:0] dsh;
    d_d = d_i;
    for (int l = 0; l < NLANE; l++) begin
      dsh = (l < 2) ? (RW'(d_i.side.dmag_x) << J) : (RW'(d_i.side.dmag_y) << J);
      if (d_i.lane[l].rem >= dsh) begin
        d_d.lane[l].rem    = d_i.lane[l].rem - dsh;
        d_d.lane[l].quo[J] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) d_q <= d_d;
  end

  assign d_o = d_q;
endmodule

// ----- design/rbe_slab_sel.sv -----
// Slab sort and parameter choice: builds signed t per lane, picks entry or exit.
// Depends on rbe_pkg.
module rbe_slab_sel (
  input  logic          clk_i,
  input  logic          en_i,
  input  rbe_pkg::div_t d_i,
  output rbe_pkg::sel_t s_o
);
  import rbe_pkg::*;

  sel_t s_d, s_q;

  always_comb begin
    logic signed [31:0] t [NLANE];
    logic signed [31:0] lo_x, hi_x, lo_y, hi_y, tmin, tmax;
    logic [31:0] m;
    for (int l = 0; l < NLANE; l++) begin
      m = d_i.lane[l].ovf ? TSAT : {1'b0, d_i.lane[l].quo};
      t[l] = d_i.lane[l].neg ? -$signed(m) : $signed(m);
    end
    lo_x = (t[0] < t[1]) ? t[0] : t[1];
    hi_x = (t[0] < t[1]) ? t[1] : t[0];
    lo_y = (t[2] < t[3]) ? t[2] : t[3];
    hi_y = (t[2] < t[3]) ? t[3] : t[2];
    if (d_i.side.par_x) begin
      lo_x = -$signed(TSAT);
      hi_x = $signed(TSAT);
    end
    if (d_i.side.par_y) begin
      lo_y = -$signed(TSAT);
      hi_y = $signed(TSAT);
    end
    tmin = (lo_x > lo_y) ? lo_x : lo_y;
    tmax = (hi_x < hi_y) ? hi_x : hi_y;
    s_d.side      = d_i.side;
    s_d.no_dir    = d_i.side.par_x & d_i.side.par_y;
    s_d.used_exit = !(tmin > 0);
    s_d.t         = (tmin > 0) ? tmin : tmax;
    s_d.sat       = (!d_i.side.par_x & (d_i.lane[0].ovf | d_i.lane[1].ovf)) |
                    (!d_i.side.par_y & (d_i.lane[2].ovf | d_i.lane[3].ovf));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s_q <= s_d;
  end

  assign s_o = s_q;
endmodule

// ----- design/rbe_move.sv -----
// Point step: multiply |dir| by |t|, then scale, add origin and clamp.
// Two register stages; the second is the output register. Depends on rbe_pkg.
module rbe_move #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_a_i,
  input  logic               en_b_i,
  input  rbe_pkg::sel_t      s_i,
  output logic signed [31:0] hit_x_o,
  output logic signed [31:0] hit_y_o,
  output logic               used_exit_o,
  output logic               no_dir_o,
  output logic               sat_o
);
  import rbe_pkg::*;

  logic [62:0] px_d, px_q, py_d, py_q;
  logic        nx_d, nx_q, ny_d, ny_q;
  sel_t        s_q;
  logic signed [31:0] hx_d, hy_d, hx_q, hy_q;
  logic        ue_d, ue_q, nd_q, st_d, st_q;

  // stage A: magnitudes and products
  always_comb begin
    logic [30:0] tm;
    tm   = s_i.t[31] ? 31'(-s_i.t) : s_i.t[30:0];
    px_d = 63'(s_i.side.dmag_x) * 63'(tm);
    py_d = 63'(s_i.side.dmag_y) * 63'(tm);
    nx_d = s_i.side.dir_x[31] ^ s_i.t[31];
    ny_d = s_i.side.dir_y[31] ^ s_i.t[31];
  end

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      px_q <= px_d;
      py_q <= py_d;
      nx_q <= nx_d;
      ny_q <= ny_d;
      s_q  <= s_i;
    end
  end

  // stage B: scale toward zero, add origin, clamp
  always_comb begin
    logic signed [64:0] sx, sy, hx, hy;
    logic ox, oy;
    sx = nx_q ? -$signed({2'b0, px_q >> FRAC_BITS}) : $signed({2'b0, px_q >> FRAC_BITS});
    sy = ny_q ? -$signed({2'b0, py_q >> FRAC_BITS}) : $signed({2'b0, py_q >> FRAC_BITS});
    hx = 65'(s_q.side.org_x) + sx;
    hy = 65'(s_q.side.org_y) + sy;
    ox = (hx > 65'sh7FFF_FFFF) | (hx < -65'sh8000_0000);
    oy = (hy > 65'sh7FFF_FFFF) | (hy < -65'sh8000_0000);
    hx_d = (hx > 65'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
           (hx < -65'sh8000_0000) ? 32'sh8000_0000 : hx[31:0];
    hy_d = (hy > 65'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
           (hy < -65'sh8000_0000) ? 32'sh8000_0000 : hy[31:0];
    ue_d = s_q.used_exit;
    st_d = s_q.sat | ox | oy;
    if (s_q.no_dir) begin
      hx_d = s_q.side.org_x;
      hy_d = s_q.side.org_y;
      ue_d = 1'b0;
      st_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      hx_q <= hx_d;
      hy_q <= hy_d;
      ue_q <= ue_d;
      nd_q <= s_q.no_dir;
      st_q <= st_d;
    end
  end

  assign hit_x_o     = hx_q;
  assign hit_y_o     = hy_q;
  assign used_exit_o = ue_q;
  assign no_dir_o    = nd_q;
  assign sat_o       = st_q;
endmodule

// ----- tb/sv/tb_rbe_if.sv -----
// APB bundle shared by the testbench top and the checker.
// The ray and hit channels use the design interfaces rbe_in_if and rbe_out_if.
`timescale 1ns / 100ps
interface tb_apb_if;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  modport source (output psel, penable, pwrite, paddr, pwdata,
                  input prdata, pready);
  modport sink   (input psel, penable, pwrite, paddr, pwdata,
                  output prdata, pready);
endinterface

// ----- tb/sv/tb_rbe_checker.sv -----
// Checker for the ray/box exit point block: predicts each hit from accepted
// rays and the limit register, and compares hit transfers in order.
// Depends on rbe_in_if, rbe_out_if and tb_apb_if.
`timescale 1ns / 100ps
module tb_rbe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbe_in_if           ray,
  rbe_out_if          hit,
  tb_apb_if           apb,
  output int          fail_cnt_o,
  output int          pending_o
);
  localparam int FRAC = 16;
  localparam logic signed [63:0] TMAX = 64'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic               used_exit;
    logic               no_direction;
    logic               saturated;
  } hit_t;

  hit_t        hit_q[$];
  logic [15:0] limit_q;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = (v < 0) ? -v : v;
  endfunction

  // Slab parameter (bound - origin) / dir, truncated, clamped to 31-bit magnitude.
  function automatic logic signed [63:0] slab_t(input logic [15:0] bound,
      input logic signed [63:0] org, input logic signed [63:0] dir, inout logic sat);
    logic signed [63:0] num;
    logic [63:0] n, d, q;
    num = ($signed({48'd0, bound}) <<< FRAC) - org;
    n = mag(num);
    d = mag(dir);
    q = (n << FRAC) / d;  // n < 2^49, no overflow
    if (q > TMAX) begin
      q = TMAX;
      sat = 1'b1;
    end
    slab_t = ((num < 0) != (dir < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] step_point(input logic signed [63:0] org,
      input logic signed [63:0] dir, input logic signed [63:0] t, inout logic sat);
    logic [63:0] p;
    logic signed [63:0] h;
    p = (mag(dir) * mag(t)) >> FRAC;
    h = org + (((dir < 0) != (t < 0)) ? -$signed(p) : $signed(p));
    if (h > TMAX) begin
      h = TMAX;
      sat = 1'b1;
    end
    if (h < -TMAX - 1) begin
      h = -TMAX - 1;
      sat = 1'b1;
    end
    step_point = h[31:0];
  endfunction

  function automatic hit_t exit_point();
    hit_t r;
    logic signed [63:0] dx, dy, ox, oy, a, b, lx, hx, ly, hy, tmin, tmax, t;
    logic px, py, sat;
    dx = ray.dir_x; dy = ray.dir_y; ox = ray.origin_x; oy = ray.origin_y;
    px = mag(dx) <= limit_q;
    py = mag(dy) <= limit_q;
    sat = 1'b0;
    lx = -TMAX; hx = TMAX; ly = -TMAX; hy = TMAX;
    r = '0;
    r.hit_x = ox[31:0];
    r.hit_y = oy[31:0];
    r.no_direction = px && py;
    if (!(px && py)) begin
      if (!px) begin
        a = slab_t(ray.box_min_x, ox, dx, sat);
        b = slab_t(ray.box_max_x, ox, dx, sat);
        lx = (a < b) ? a : b;
        hx = (a < b) ? b : a;
      end
      if (!py) begin
        a = slab_t(ray.box_min_y, oy, dy, sat);
        b = slab_t(ray.box_max_y, oy, dy, sat);
        ly = (a < b) ? a : b;
        hy = (a < b) ? b : a;
      end
      tmin = (lx > ly) ? lx : ly;
      tmax = (hx < hy) ? hx : hy;
      r.used_exit = !(tmin > 0);
      t = r.used_exit ? tmax : tmin;
      r.hit_x = step_point(ox, dx, t, sat);
      r.hit_y = step_point(oy, dy, t, sat);
    end
    r.saturated = sat;
    exit_point = r;
  endfunction

  assign pending_o = hit_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    hit_t exp_h;
    if (!rst_ni) begin
      limit_q    <= '0;
      fail_cnt_o <= 0;
      hit_q.delete();
    end else begin
      if (ray.valid && ray.ready) hit_q.push_back(exit_point());
      if (apb.psel && apb.penable && apb.pwrite && apb.pready && apb.paddr == 3'd0)
        limit_q <= apb.pwdata[15:0];
      if (hit.valid && hit.ready) begin
        if (hit_q.size() == 0) begin
          $error("hit transfer with no ray pending");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_h = hit_q.pop_front();
          if (exp_h != {hit.hit_x, hit.hit_y, hit.used_exit, hit.no_direction,
                        hit.saturated}) begin
            fail_cnt_o <= fail_cnt_o + 1;
            if (exp_h.hit_x != hit.hit_x)
              $error("hit_x exp %0d got %0d", exp_h.hit_x, hit.hit_x);
            if (exp_h.hit_y != hit.hit_y)
              $error("hit_y exp %0d got %0d", exp_h.hit_y, hit.hit_y);
            if (exp_h.used_exit != hit.used_exit)
              $error("used_exit exp %0d got %0d", exp_h.used_exit, hit.used_exit);
            if (exp_h.no_direction != hit.no_direction)
              $error("no_direction exp %0d got %0d", exp_h.no_direction,
                     hit.no_direction);
            if (exp_h.saturated != hit.saturated)
              $error("saturated exp %0d got %0d", exp_h.saturated, hit.saturated);
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for ray_box_exit_point_2d_top: drives rays, hit stalls and
// limit writes; tb_rbe_checker predicts and compares. Needs the design files.
`timescale 1ns / 100ps
module tb_top;
  localparam int LATENCY  = 35;
  localparam int WD_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending;
  int   send_idle_pct, recv_idle_pct;
  int   stall_cnt;
  bit   timed_out;

  rbe_in_if  ray_if ();
  rbe_out_if hit_if ();
  tb_apb_if  apb_if ();

  always #5 clk_i = ~clk_i;

  ray_box_exit_point_2d_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ray_i   (ray_if),
    .hit_o   (hit_if),
    .psel    (apb_if.psel),
    .penable (apb_if.penable),
    .pwrite  (apb_if.pwrite),
    .paddr   (apb_if.paddr),
    .pwdata  (apb_if.pwdata),
    .prdata  (apb_if.prdata),
    .pready  (apb_if.pready)
  );

  tb_rbe_checker i_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ray        (ray_if),
    .hit        (hit_if),
    .apb        (apb_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // Receiver: stall at the current rate, redrawn each falling edge.
  always @(negedge clk_i) begin
    hit_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((ray_if.valid && ray_if.ready) || (hit_if.valid && hit_if.ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WD_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("== FAIL ==");
      $finish;
    end
  end

  // Random 32-bit value biased toward extremes and small magnitudes.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: rand_word = 32'h7FFF_FFFF;
      1: rand_word = 32'h8000_0000;
      2: rand_word = $urandom_range(8) - 4;
      3: rand_word = $urandom_range(4 << 16) - (2 << 16);
      4: rand_word = $urandom;
      default: rand_word = $signed($urandom) >>> $urandom_range(24);
    endcase
  endfunction

  function automatic logic [15:0] rand_bound();
    rand_bound = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(64));
  endfunction

  // Present one ray and hold it until the transfer.
  task automatic send_ray(input logic [31:0] dx, dy, ox, oy,
                          input logic [15:0] x0, y0, x1, y1);
    while ($urandom_range(99) < send_idle_pct) begin
      ray_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    ray_if.valid     <= 1'b1;
    ray_if.dir_x     <= dx;
    ray_if.dir_y     <= dy;
    ray_if.origin_x  <= ox;
    ray_if.origin_y  <= oy;
    ray_if.box_min_x <= x0;
    ray_if.box_min_y <= y0;
    ray_if.box_max_x <= x1;
    ray_if.box_max_y <= y1;
    do @(posedge clk_i); while (!ray_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_rand_ray();
    send_ray(rand_word(), rand_word(), rand_word(), rand_word(),
             rand_bound(), rand_bound(), rand_bound(), rand_bound());
  endtask

  // Drop valid and wait until every pending hit has transferred.
  task automatic drain();
    ray_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] val);
    apb_if.psel    <= 1'b1;
    apb_if.pwrite  <= 1'b1;
    apb_if.paddr   <= 3'd0;
    apb_if.pwdata  <= {16'd0, val};
    @(negedge clk_i);
    apb_if.penable <= 1'b1;
    @(negedge clk_i);
    apb_if.psel    <= 1'b0;
    apb_if.penable <= 1'b0;
    apb_if.pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] limits[5];
    limits = '{16'd0, 16'd65535, 16'd3, 16'd300, 16'd0};
    send_idle_pct  = 24;
    recv_idle_pct  = 88;
    stall_cnt      = 0;
    timed_out      = 1'b0;
    ray_if.valid   = 1'b0;
    {ray_if.dir_x, ray_if.dir_y, ray_if.origin_x, ray_if.origin_y} = '0;
    {ray_if.box_min_x, ray_if.box_min_y, ray_if.box_max_x, ray_if.box_max_y} = '0;
    hit_if.ready   = 1'b0;
    apb_if.psel    = 1'b0;
    apb_if.penable = 1'b0;
    apb_if.pwrite  = 1'b0;
    apb_if.paddr   = '0;
    apb_if.pwdata  = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, both axes parallel, one axis parallel, swapped
    // bounds, entry versus exit, saturation.
    send_ray(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 16'd2, 16'd3, 16'd5, 16'd7);
    send_ray(32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'h0004_0000,
             16'd2, 16'd3, 16'd5, 16'd7);
    send_ray(32'h0, 32'h0, 32'h1234_5678, 32'hFEDC_BA98, 16'd1, 16'd1, 16'd2, 16'd2);
    send_ray(32'h0, 32'hFFFF_0000, 32'h0, 32'h0010_0000, 16'd0, 16'd1, 16'd9, 16'd4);
    send_ray(32'h0002_0000, 32'h0, 32'h0, 32'h0, 16'd8, 16'd0, 16'd1, 16'd3);
    send_ray(32'h0000_0001, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
             16'hFFFF, 16'hFFFF, 16'h0, 16'h0);
    send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             16'hFFFF, 16'h0, 16'h0, 16'hFFFF);
    send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF,
             16'hFFFF, 16'hFFFF);
    send_ray(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    send_ray(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
             16'd0, 16'd0, 16'd0, 16'd0);
    // Pause until every hit is back before going on.
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      if (ph == 1) begin
        // Near-parallel directions right at the limit.
        send_ray(32'h0000_FFFF, 32'hFFFF_0001, 32'h0, 32'h0, 16'd1, 16'd1, 16'd2, 16'd2);
        send_ray(32'h0001_0000, 32'h0000_FFFF, 32'h0, 32'h0, 16'd1, 16'd1, 16'd2, 16'd2);
      end
      if (ph == 3) begin
        send_idle_pct = 88;
        recv_idle_pct = 24;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < 250; k++) begin
        // Mostly rays that start near the box and reach it at a sane rate.
        if ($urandom_range(3) != 0)
          send_ray($urandom_range(8 << 16) - (4 << 16),
                   $urandom_range(8 << 16) - (4 << 16),
                   $urandom_range(200 << 16), $urandom_range(200 << 16),
                   16'($urandom_range(150)), 16'($urandom_range(150)),
                   16'($urandom_range(150)), 16'($urandom_range(150)));
        else
          send_rand_ray();
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
